// ----- hw/rtl/rf_switch_frame_encoder_unit_assert.svh -----
// assertion macros for the frame encoder
`ifndef RF_SWITCH_FRAME_ENCODER_UNIT_ASSERT_SVH
`define RF_SWITCH_FRAME_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define RFSE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfse check failed");

// next-cycle implication
`define RFSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfse check failed");

`endif

// ----- hw/rtl/rfse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rfse_pkg;

   localparam int SYNC_ZEROS_DEFAULT = 12;
   // sync one bit, five bytes with parity, closing bit
   localparam int FRAME_TAIL_BITS = 47;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CMD_ON_BYTE = 8'h10;
   localparam logic [7:0] CMD_OFF_BYTE = 8'h00;

   localparam logic [15:0] SHORT_PULSE_RESET = 16'd400;
   localparam logic [15:0] LONG_PULSE_RESET = 16'd600;
   localparam logic [15:0] TAIL_GAP_RESET = 16'd10000;
   localparam logic [7:0] CHECKSUM_SEED_RESET = 8'd6;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_SHORT_PULSE = 2'd0,
      REG_LONG_PULSE = 2'd1,
      REG_TAIL_GAP = 2'd2,
      REG_CHECKSUM_SEED = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_OFF = 2'd0,
      CMD_ON = 2'd1,
      CMD_DIM = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic [15:0] housecode;
      logic [7:0] unit;
      logic [1:0] cmd_kind;
      logic [7:0] dim_level;
   } req_type;

   typedef struct packed {
      logic bit_value;
      logic [16:0] first_pulse;
      logic [16:0] second_pulse;
      logic last_bit;
   } rsp_type;

   typedef struct packed {
      logic [15:0] short_pulse;
      logic [15:0] long_pulse;
      logic [15:0] tail_gap;
   } pulse_cfg_type;

endpackage
`default_nettype wire

// ----- hw/rtl/rfse_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rfse_front #(
   parameter int SyncZeros = rfse_pkg::SYNC_ZEROS_DEFAULT,
   localparam int FrameBits = SyncZeros + rfse_pkg::FRAME_TAIL_BITS
) (
   input wire logic req_valid,
   output logic req_stall,
   input wire rfse_pkg::req_type req_data,
   input wire logic [7:0] checksum_seed,
   input wire logic q_full,
   output logic q_push,
   output logic [FrameBits-1:0] q_frame
);

   logic [7:0] cmd_byte;
   logic [7:0] house_hi;
   logic [7:0] house_lo;
   logic [7:0] checksum;

   always_comb begin
      unique case (rfse_pkg::cmd_kind_type'(req_data.cmd_kind))
         rfse_pkg::CMD_OFF: begin
            cmd_byte = rfse_pkg::CMD_OFF_BYTE;
         end
         rfse_pkg::CMD_ON: begin
            cmd_byte = rfse_pkg::CMD_ON_BYTE;
         end
         default: begin
            cmd_byte = req_data.dim_level;
         end
      endcase
   end

   assign house_hi = req_data.housecode[15:8];
   assign house_lo = req_data.housecode[7:0];
   assign checksum = checksum_seed + house_hi + house_lo + req_data.unit + cmd_byte;

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

   // bits leave from the top end of the frame vector
   assign q_frame = {{SyncZeros{1'b0}}, 1'b1,
                     house_hi, ^house_hi,
                     house_lo, ^house_lo,
                     req_data.unit, ^req_data.unit,
                     cmd_byte, ^cmd_byte,
                     checksum, ^checksum,
                     1'b0};

endmodule
`default_nettype wire

// ----- hw/rtl/rfse_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rfse_queue #(
   parameter int Width = 59,
   parameter int Depth = rfse_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CntW = $clog2(Depth + 1)
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire logic [Width-1:0] push_data,
   output logic full,
   input wire logic pop,
   output logic head_valid,
   output logic [Width-1:0] head_data
);

   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(Depth);

   logic [Width-1:0] entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/rfse_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rfse_back #(
   parameter int SyncZeros = rfse_pkg::SYNC_ZEROS_DEFAULT,
   localparam int FrameBits = SyncZeros + rfse_pkg::FRAME_TAIL_BITS,
   localparam int CntW = $clog2(FrameBits)
) (
   input wire logic clock,
   input wire logic reset,
   input wire rfse_pkg::pulse_cfg_type pulse_cfg,
   input wire logic q_valid,
   input wire logic [FrameBits-1:0] q_frame,
   output logic q_pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rfse_pkg::rsp_type rsp_data
);

   localparam logic [CntW-1:0] StartCount = CntW'(FrameBits - 2);

   logic active_ff, active_in;
   logic [FrameBits-1:0] shift_ff, shift_in;
   logic [CntW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   rfse_pkg::rsp_type rsp_ff, rsp_in;

   logic advance;
   logic start;
   logic emit;
   logic emit_bit;
   logic emit_last;
   logic [16:0] pulse_len;

   always_comb begin
      advance = !rsp_valid_ff || !rsp_stall;
      start = advance && !active_ff && q_valid;
      emit = advance && (active_ff || q_valid);
      emit_bit = active_ff ? shift_ff[FrameBits-1] : q_frame[FrameBits-1];
      emit_last = active_ff && (count_ff == '0);
      pulse_len = emit_bit ? {1'b0, pulse_cfg.long_pulse} : {1'b0, pulse_cfg.short_pulse};
      q_pop = start;

      active_in = active_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (start) begin
         active_in = 1'b1;
         shift_in = q_frame << 1;
         count_in = StartCount;
      end else if (advance && active_ff) begin
         shift_in = shift_ff << 1;
         if (emit_last) begin
            active_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_in.bit_value = emit_bit;
         rsp_in.first_pulse = pulse_len;
         rsp_in.second_pulse = emit_last ? pulse_len + {1'b0, pulse_cfg.tail_gap}
                                         : pulse_len;
         rsp_in.last_bit = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/rf_switch_frame_encoder_unit.sv -----
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | rfse_pkg::req_type
// rsp     | out       | rsp_valid / rsp_stall  | rfse_pkg::rsp_type, one per frame bit
// csr     | in/out    | apb write, pready high | four pulse and checksum registers
//
// a command gives SyncZeros+47 bit transfers (59 by default), one per cycle from the
// back serializer while rsp_stall is low; frames follow back to back with no gap
// reset clears the queue, the serializer and the output valid flag; registers take defaults
// req_stall is high while the frame queue (QueueDepth entries, two by default) is full
// rsp_stall holds the output register and pauses the serializer
`timescale 1ns / 1ps
`default_nettype none
`include "rf_switch_frame_encoder_unit_assert.svh"
module rf_switch_frame_encoder_unit #(
   parameter int SyncZeros = rfse_pkg::SYNC_ZEROS_DEFAULT,
   parameter int QueueDepth = rfse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire rfse_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rfse_pkg::rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [rfse_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [rfse_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rfse_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int FrameBits = SyncZeros + rfse_pkg::FRAME_TAIL_BITS;

   logic [15:0] short_pulse_ff, short_pulse_in;
   logic [15:0] long_pulse_ff, long_pulse_in;
   logic [15:0] tail_gap_ff, tail_gap_in;
   logic [7:0] checksum_seed_ff, checksum_seed_in;
   logic csr_write;
   rfse_pkg::reg_index_type csr_index;
   rfse_pkg::pulse_cfg_type pulse_cfg;

   logic q_full;
   logic q_push;
   logic q_pop;
   logic q_valid;
   logic [FrameBits-1:0] push_frame;
   logic [FrameBits-1:0] head_frame;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = rfse_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      short_pulse_in = short_pulse_ff;
      long_pulse_in = long_pulse_ff;
      tail_gap_in = tail_gap_ff;
      checksum_seed_in = checksum_seed_ff;
      if (csr_write) begin
         unique case (csr_index)
            rfse_pkg::REG_SHORT_PULSE: short_pulse_in = csr_pwdata[15:0];
            rfse_pkg::REG_LONG_PULSE: long_pulse_in = csr_pwdata[15:0];
            rfse_pkg::REG_TAIL_GAP: tail_gap_in = csr_pwdata[15:0];
            rfse_pkg::REG_CHECKSUM_SEED: checksum_seed_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rfse_pkg::REG_SHORT_PULSE: csr_prdata = {16'd0, short_pulse_ff};
         rfse_pkg::REG_LONG_PULSE: csr_prdata = {16'd0, long_pulse_ff};
         rfse_pkg::REG_TAIL_GAP: csr_prdata = {16'd0, tail_gap_ff};
         rfse_pkg::REG_CHECKSUM_SEED: csr_prdata = {24'd0, checksum_seed_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_pulse_ff <= rfse_pkg::SHORT_PULSE_RESET;
         long_pulse_ff <= rfse_pkg::LONG_PULSE_RESET;
         tail_gap_ff <= rfse_pkg::TAIL_GAP_RESET;
         checksum_seed_ff <= rfse_pkg::CHECKSUM_SEED_RESET;
      end else begin
         short_pulse_ff <= short_pulse_in;
         long_pulse_ff <= long_pulse_in;
         tail_gap_ff <= tail_gap_in;
         checksum_seed_ff <= checksum_seed_in;
      end
   end

   assign pulse_cfg = '{short_pulse: short_pulse_ff,
                        long_pulse: long_pulse_ff,
                        tail_gap: tail_gap_ff};

   rfse_front #(
      .SyncZeros(SyncZeros)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .checksum_seed(checksum_seed_ff),
      .q_full(q_full),
      .q_push(q_push),
      .q_frame(push_frame)
   );

   rfse_queue #(
      .Width(FrameBits),
      .Depth(QueueDepth)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(push_frame),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_valid),
      .head_data(head_frame)
   );

   rfse_back #(
      .SyncZeros(SyncZeros)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .pulse_cfg(pulse_cfg),
      .q_valid(q_valid),
      .q_frame(head_frame),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   `RFSE_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_full, !q_push)
   `RFSE_ASSERT_IMPLY(a_last_bit_is_zero, clock, reset,
      rsp_valid && rsp_data.last_bit,
      !rsp_data.bit_value && rsp_data.first_pulse == {1'b0, short_pulse_ff})
   `RFSE_ASSERT_IMPLY(a_equal_pulses, clock, reset,
      rsp_valid && !rsp_data.last_bit, rsp_data.first_pulse == rsp_data.second_pulse)
   `RFSE_ASSERT_NEXT(a_stall_holds_last, clock, reset,
      rsp_valid && rsp_stall && rsp_data.last_bit, rsp_valid && rsp_data.last_bit)

endmodule
`default_nettype wire
